### rtl/nearest_blob_track_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest blob track table
// Short forms for the clocked property checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef NEAREST_BLOB_TRACK_TABLE_ASSERT_SVH
`define NEAREST_BLOB_TRACK_TABLE_ASSERT_SVH

// same-cycle implication
`define NBTT_ASSERT_IMPLY(label, clk, rst, cond, chk, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (chk)) \
      else $error(msg);

// next-cycle implication
`define NBTT_ASSERT_NEXT(label, clk, rst, cond, chk, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (chk)) \
      else $error(msg);

`endif

### rtl/nbtt_pkg.sv
// ----------------------------------------------------------------------------
// nbtt_pkg
// Shared sizes, types and state codes of the nearest blob track table.
// ----------------------------------------------------------------------------
package nbtt_pkg;

   localparam int TRACK_DEPTH = 32;
   localparam int SLOT_W      = $clog2(TRACK_DEPTH);
   localparam int COUNT_W     = $clog2(TRACK_DEPTH + 1);
   localparam int ID_W        = 16;
   localparam int COORD_W     = 12;
   localparam int DIAG_W      = 13;
   localparam int RATIO_W     = 8;
   localparam int RATIO_FRAC  = 4;
   localparam int LIM_W       = DIAG_W + RATIO_W;
   localparam int LIM_SQ_W    = 2 * LIM_W;
   localparam int D2_W        = 2 * COORD_W + 1;
   localparam int ENTRY_W     = 2 * COORD_W + ID_W;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [RATIO_W-1:0] RATIO_RESET = 8'd24;

   typedef struct packed {
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
      logic [LIM_SQ_W-1:0] lim_sq;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } qhead_type;

   typedef struct packed {
      logic [ID_W-1:0]   blob_id;
      logic [SLOT_W-1:0] slot;
      logic              is_new;
      logic              dropped;
   } result_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } state_type;

endpackage

### rtl/nearest_blob_track_table.sv
// ----------------------------------------------------------------------------
// nearest_blob_track_table
// Nearest-neighbor centroid tracker over a table of up to 32 tracked blobs.
// ----------------------------------------------------------------------------
// Each item is one detected blob (center and bounding diagonal). The block
// finds the stored track nearest to it by squared distance (lowest slot on a
// tie); when that distance is below diagonal * csr ratio / 16 the track takes
// the new center and keeps its id, otherwise a new track is appended with the
// next id (1 upward, 0 never used), or the blob is reported dropped when all
// 32 slots are taken. Results come out one per item, in order. For each item
// the back end takes it from the queue, reads the stored tracks one per cycle
// from the single read port of the track memory (a linear search), flushes
// the distance pipeline, closes the search and then decides; it takes a new
// item only once the last one is decided. Items are buffered in a two-entry
// queue ahead of the search, and the result sits in an output register, so
// the input keeps taking items while a result waits to be popped, until the
// queue fills. On input, diagonal * ratio is registered in the limit stage
// and squared as the item is written into the queue. The ratio register
// (csr_wdata, 4.4 fixed point, reset 1.5) must only be written while no item
// is in flight; the track memory needs no clearing after reset since only
// slots below the track count are ever read.
// ----------------------------------------------------------------------------
`include "nearest_blob_track_table_assert.svh"

module nearest_blob_track_table (
   input  logic                         clock,
   input  logic                         reset,
   // configuration
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [nbtt_pkg::RATIO_W-1:0] csr_wdata,
   // blob items in
   input  logic [nbtt_pkg::COORD_W-1:0] req_center_x,
   input  logic [nbtt_pkg::COORD_W-1:0] req_center_y,
   input  logic [nbtt_pkg::DIAG_W-1:0]  req_diagonal,
   input  logic                         req_push,
   output logic                         req_full,
   // track results out
   output logic [nbtt_pkg::ID_W-1:0]    rsp_blob_id,
   output logic [nbtt_pkg::SLOT_W-1:0]  rsp_slot,
   output logic                         rsp_is_new,
   output logic                         rsp_dropped,
   output logic                         rsp_empty,
   input  logic                         rsp_pop
);
   import nbtt_pkg::*;

   qhead_type  head;      // oldest queued item, with its limit squared
   logic       head_pop;
   result_type rsp;

   // front: ratio register, limit = diag * ratio, limit squared, item queue
   nbtt_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_wdata    (csr_wdata),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_diagonal (req_diagonal),
      .req_push     (req_push),
      .req_full     (req_full),
      .head         (head),
      .head_pop     (head_pop)
   );

   // back: linear search, match decision, table write-back, output register
   nbtt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .head_pop  (head_pop),
      .rsp       (rsp),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

   assign rsp_blob_id = rsp.blob_id;
   assign rsp_slot    = rsp.slot;
   assign rsp_is_new  = rsp.is_new;
   assign rsp_dropped = rsp.dropped;

   // a dropped blob carries no id, no slot and no new flag
   `NBTT_ASSERT_IMPLY(a_drop_fields, clock, reset, !rsp_empty && rsp_dropped,
      rsp_blob_id == '0 && rsp_slot == '0 && !rsp_is_new, "dropped item with fields set")
   // id zero is reserved for dropped blobs
   `NBTT_ASSERT_IMPLY(a_id_nonzero, clock, reset, !rsp_empty && !rsp_dropped,
      rsp_blob_id != '0, "tracked item with id zero")
   // the back end only takes an item that the queue holds
   `NBTT_ASSERT_IMPLY(a_pop_valid, clock, reset, head_pop, head.valid,
      "queue popped while empty")
   // one item at a time: a take is always followed by a search
   `NBTT_ASSERT_NEXT(a_pop_spacing, clock, reset, head_pop, !head_pop,
      "queue popped on consecutive cycles")

endmodule

### rtl/nbtt_ram.sv
// ----------------------------------------------------------------------------
// nbtt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nbtt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### rtl/nbtt_front.sv
// ----------------------------------------------------------------------------
// nbtt_front
// Input side: ratio register, match limit squared, short item queue.
// ----------------------------------------------------------------------------
module nbtt_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [nbtt_pkg::RATIO_W-1:0]    csr_wdata,
   input  logic [nbtt_pkg::COORD_W-1:0]    req_center_x,
   input  logic [nbtt_pkg::COORD_W-1:0]    req_center_y,
   input  logic [nbtt_pkg::DIAG_W-1:0]     req_diagonal,
   input  logic                            req_push,
   output logic                            req_full,
   output nbtt_pkg::qhead_type             head,
   input  logic                            head_pop
);
   import nbtt_pkg::*;

   logic [RATIO_W-1:0]  ratio_ff, ratio_in;

   // stage: limit = diagonal * ratio
   logic                s_valid_ff, s_valid_in;
   logic [COORD_W-1:0]  s_x_ff, s_x_in;
   logic [COORD_W-1:0]  s_y_ff, s_y_in;
   logic [LIM_W-1:0]    s_lim_ff, s_lim_in;

   // queue
   item_type            q_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0] q_count_ff, q_count_in;

   logic                q_full;
   logic                advance;
   logic                accept;
   logic [LIM_SQ_W-1:0] lim_sq;
   item_type            q_entry;

   assign csr_ready = 1'b1;
   assign ratio_in  = (csr_valid && csr_ready) ? csr_wdata : ratio_ff;

   assign q_full   = (q_count_ff == QCOUNT_W'(QUEUE_DEPTH));
   assign advance  = s_valid_ff && !q_full;
   assign req_full = s_valid_ff && q_full;
   assign accept   = req_push && !req_full;

   assign s_valid_in = accept || (s_valid_ff && !advance);
   assign s_x_in     = accept ? req_center_x : s_x_ff;
   assign s_y_in     = accept ? req_center_y : s_y_ff;
   assign s_lim_in   = accept ? (LIM_W'(req_diagonal) * LIM_W'(ratio_ff)) : s_lim_ff;

   assign lim_sq  = LIM_SQ_W'(s_lim_ff) * LIM_SQ_W'(s_lim_ff);
   assign q_entry = '{x: s_x_ff, y: s_y_ff, lim_sq: lim_sq};

   assign wr_ptr_in  = advance ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in  = head_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign q_count_in = q_count_ff + QCOUNT_W'(advance) - QCOUNT_W'(head_pop);

   assign head.valid = (q_count_ff != '0);
   assign head.item  = q_mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff   <= RATIO_RESET;
         s_valid_ff <= 1'b0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         q_count_ff <= '0;
      end else begin
         ratio_ff   <= ratio_in;
         s_valid_ff <= s_valid_in;
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         q_count_ff <= q_count_in;
      end
   end

   always_ff @(posedge clock) begin
      s_x_ff   <= s_x_in;
      s_y_ff   <= s_y_in;
      s_lim_ff <= s_lim_in;
      if (advance) begin
         q_mem_ff[wr_ptr_ff] <= q_entry;
      end
   end

endmodule

### rtl/nbtt_back.sv
// ----------------------------------------------------------------------------
// nbtt_back
// Track search and update: scans the track memory, picks the nearest entry,
// writes back and hands the result to the output register.
// ----------------------------------------------------------------------------
module nbtt_back (
   input  logic                 clock,
   input  logic                 reset,
   input  nbtt_pkg::qhead_type  head,
   output logic                 head_pop,
   output nbtt_pkg::result_type rsp,
   output logic                 rsp_empty,
   input  logic                 rsp_pop
);
   import nbtt_pkg::*;

   state_type            state_ff, state_in;
   item_type             item_ff, item_in;
   logic [COUNT_W-1:0]   rd_idx_ff, rd_idx_in;

   // search pipeline: read, distance parts, squared distance
   logic                 v1_ff, v2_ff, v3_ff;
   logic [SLOT_W-1:0]    idx1_ff, idx2_ff, idx3_ff;
   logic [COORD_W-1:0]   dx_ff, dx_in, dy_ff, dy_in;
   logic [ID_W-1:0]      id2_ff, id3_ff;
   logic [D2_W-1:0]      d2_ff, d2_in;

   logic                 found_ff;
   logic [D2_W-1:0]      best_d2_ff;
   logic [SLOT_W-1:0]    best_idx_ff;
   logic [ID_W-1:0]      best_id_ff;

   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [ID_W-1:0]      next_id_ff, next_id_in;

   logic                 out_valid_ff, out_valid_in;
   result_type           out_ff, out_in;

   logic                 issue;
   logic                 scan_done;
   logic                 commit;
   logic                 out_free;
   logic                 take_best;

   logic [ENTRY_W-1:0]   rd_data;
   logic [COORD_W-1:0]   rx, ry;
   logic [ID_W-1:0]      rid;
   logic [2*COORD_W-1:0] sq_x, sq_y;
   logic [LIM_SQ_W-1:0]  d2_scaled;
   logic                 match;
   logic                 has_room;
   logic                 wr_en;
   logic [SLOT_W-1:0]    wr_addr;
   logic [ENTRY_W-1:0]   wr_data;
   result_type           res;

   nbtt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TRACK_DEPTH)
   ) u_track_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (rd_idx_ff[SLOT_W-1:0]),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      head_pop  = 1'b0;
      issue     = 1'b0;
      scan_done = 1'b0;
      commit    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            head_pop = head.valid;
         end
         ST_SCAN: begin
            issue     = (rd_idx_ff < count_ff);
            scan_done = !issue && !v1_ff && !v2_ff && !v3_ff;
         end
         ST_DECIDE: begin
            commit = out_free;
         end
         default: begin
            head_pop = 1'b0;
         end
      endcase
   end

   assign out_free = !out_valid_ff || rsp_pop;

   assign item_in   = head_pop ? head.item : item_ff;
   assign rd_idx_in = head_pop ? '0 : (issue ? rd_idx_ff + 1'b1 : rd_idx_ff);

   // distance parts
   assign rx    = rd_data[ENTRY_W-1 -: COORD_W];
   assign ry    = rd_data[ID_W +: COORD_W];
   assign rid   = rd_data[ID_W-1:0];
   assign dx_in = (item_ff.x >= rx) ? item_ff.x - rx : rx - item_ff.x;
   assign dy_in = (item_ff.y >= ry) ? item_ff.y - ry : ry - item_ff.y;

   assign sq_x  = (2*COORD_W)'(dx_ff) * (2*COORD_W)'(dx_ff);
   assign sq_y  = (2*COORD_W)'(dy_ff) * (2*COORD_W)'(dy_ff);
   assign d2_in = {1'b0, sq_x} + {1'b0, sq_y};

   // strict less keeps the lowest index on a tie
   assign take_best = v3_ff && (!found_ff || (d2_ff < best_d2_ff));

   // d2 * 256 < (diag * ratio)^2, both sides exact
   assign d2_scaled = LIM_SQ_W'({best_d2_ff, {(2*RATIO_FRAC){1'b0}}});
   assign match     = found_ff && (d2_scaled < item_ff.lim_sq);
   assign has_room  = (count_ff < COUNT_W'(TRACK_DEPTH));

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = best_idx_ff;
      wr_data = {item_ff.x, item_ff.y, best_id_ff};
      res     = '{blob_id: '0, slot: '0, is_new: 1'b0, dropped: 1'b1};
      if (match) begin
         wr_en = commit;
         res   = '{blob_id: best_id_ff, slot: best_idx_ff, is_new: 1'b0, dropped: 1'b0};
      end else if (has_room) begin
         wr_en   = commit;
         wr_addr = count_ff[SLOT_W-1:0];
         wr_data = {item_ff.x, item_ff.y, next_id_ff};
         res     = '{blob_id: next_id_ff, slot: count_ff[SLOT_W-1:0], is_new: 1'b1,
                     dropped: 1'b0};
      end
   end

   always_comb begin
      count_in   = count_ff;
      next_id_in = next_id_ff;
      if (commit && !match && has_room) begin
         count_in   = count_ff + 1'b1;
         next_id_in = (next_id_ff == '1) ? ID_W'(1) : next_id_ff + 1'b1;
      end
   end

   assign out_valid_in = commit || (out_valid_ff && !rsp_pop);
   assign out_in       = commit ? res : out_ff;

   assign rsp       = out_ff;
   assign rsp_empty = !out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         found_ff     <= 1'b0;
         count_ff     <= '0;
         next_id_ff   <= ID_W'(1);
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         v1_ff        <= issue;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         if (head_pop) begin
            found_ff <= 1'b0;
         end else if (take_best) begin
            found_ff <= 1'b1;
         end
         count_ff     <= count_in;
         next_id_ff   <= next_id_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      rd_idx_ff <= rd_idx_in;
      idx1_ff   <= rd_idx_ff[SLOT_W-1:0];
      idx2_ff   <= idx1_ff;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      id2_ff    <= rid;
      idx3_ff   <= idx2_ff;
      id3_ff    <= id2_ff;
      d2_ff     <= d2_in;
      if (take_best) begin
         best_d2_ff  <= d2_ff;
         best_idx_ff <= idx3_ff;
         best_id_ff  <= id3_ff;
      end
      out_ff    <= out_in;
   end

endmodule

### dv/track_result_checker.sv
// ----------------------------------------------------------------------------
// track_result_checker
// Watches the blob, csr and result channels of the track table, predicts
// every result from a mirror of the track table, and compares in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module track_result_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [nbtt_pkg::RATIO_W-1:0] csr_wdata,
   input  logic [nbtt_pkg::COORD_W-1:0] req_center_x,
   input  logic [nbtt_pkg::COORD_W-1:0] req_center_y,
   input  logic [nbtt_pkg::DIAG_W-1:0]  req_diagonal,
   input  logic                         req_push,
   input  logic                         req_full,
   input  logic [nbtt_pkg::ID_W-1:0]    rsp_blob_id,
   input  logic [nbtt_pkg::SLOT_W-1:0]  rsp_slot,
   input  logic                         rsp_is_new,
   input  logic                         rsp_dropped,
   input  logic                         rsp_empty,
   input  logic                         rsp_pop,
   output int                           fail_count,
   output int                           outstanding
);

   import nbtt_pkg::*;

   // mirror of the track table
   logic [COORD_W-1:0] trk_x [TRACK_DEPTH];
   logic [COORD_W-1:0] trk_y [TRACK_DEPTH];
   logic [ID_W-1:0]    trk_id [TRACK_DEPTH];
   int                 trk_count;
   logic [ID_W-1:0]    id_next;
   logic [RATIO_W-1:0] ratio;

   result_type expected_tracks [$];
   int         errors = 0;

   // nearest-track search and table update for one blob
   function automatic result_type track_blob(input logic [COORD_W-1:0] cx,
                                             input logic [COORD_W-1:0] cy,
                                             input logic [DIAG_W-1:0]  diag);
      result_type      res;
      longint unsigned dx, dy, d2, best_d2, lim;
      int              best;
      bit              found;
      best    = 0;
      best_d2 = 0;
      found   = 0;
      for (int i = 0; i < trk_count; i++) begin
         dx = (cx >= trk_x[i]) ? longint'(cx) - longint'(trk_x[i])
                               : longint'(trk_x[i]) - longint'(cx);
         dy = (cy >= trk_y[i]) ? longint'(cy) - longint'(trk_y[i])
                               : longint'(trk_y[i]) - longint'(cy);
         d2 = dx * dx + dy * dy;
         // strict less-than keeps the lowest slot on a tie
         if (!found || d2 < best_d2) begin
            best_d2 = d2;
            best    = i;
            found   = 1;
         end
      end
      lim = longint'(diag) * longint'(ratio);
      res = '0;
      // d < diag * ratio / 16, squared on both sides
      if (found && (best_d2 << 8) < lim * lim) begin
         trk_x[best] = cx;
         trk_y[best] = cy;
         res.blob_id = trk_id[best];
         res.slot    = best[SLOT_W-1:0];
      end else if (trk_count < TRACK_DEPTH) begin
         trk_x[trk_count]  = cx;
         trk_y[trk_count]  = cy;
         trk_id[trk_count] = id_next;
         res.blob_id       = id_next;
         res.slot          = trk_count[SLOT_W-1:0];
         res.is_new        = 1'b1;
         trk_count++;
         id_next = (id_next == {ID_W{1'b1}}) ? ID_W'(1) : id_next + 1'b1;
      end else begin
         res.dropped = 1'b1;
      end
      return res;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         trk_count = 0;
         id_next   = ID_W'(1);
         ratio     = RATIO_RESET;
         expected_tracks.delete();
      end else begin
         if (csr_valid && csr_ready)
            ratio = csr_wdata;
         // pop before push: a result can never belong to the item taken this edge
         if (rsp_pop && !rsp_empty) begin
            if (expected_tracks.size() == 0) begin
               errors++;
               $display({"%0t: unexpected result, expected none, ",
                         "actual id %0d slot %0d new %0b drop %0b"},
                        $time, rsp_blob_id, rsp_slot, rsp_is_new, rsp_dropped);
            end else begin
               want = expected_tracks.pop_front();
               check_field("blob_id", want.blob_id, rsp_blob_id);
               check_field("slot", want.slot, rsp_slot);
               check_field("is_new", want.is_new, rsp_is_new);
               check_field("dropped", want.dropped, rsp_dropped);
            end
         end
         if (req_push && !req_full) begin
            want = track_blob(req_center_x, req_center_y, req_diagonal);
            expected_tracks.insert(expected_tracks.size(), want);
         end
      end
      outstanding <= expected_tracks.size();
      fail_count  <= errors;
   end

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the nearest blob track table.
// ----------------------------------------------------------------------------
// Directed blobs cover the empty table, extreme coordinates and diagonal,
// zero diagonal, exact repeats, a tie between two tracks and the strict
// match boundary. Random blobs then run under several ratio settings; most
// land near recently sent centers so tracks get matched, the rest are noise.
// Entries are never freed, so the table fills and drops show up. A separate
// checker predicts and compares; this module only drives and judges.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

   import nbtt_pkg::*;

   // settle time: longer than one item takes through the 2 input stages and a full-table search
   localparam int SETTLE_CYCLES = 64;
   // worst quiet stretch: the squeeze hold and the long stalls
   localparam int SQUEEZE_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 4000;

   logic               clock;
   logic               reset;
   logic               csr_valid;
   logic               csr_ready;
   logic [RATIO_W-1:0] csr_wdata;
   logic [COORD_W-1:0] req_center_x;
   logic [COORD_W-1:0] req_center_y;
   logic [DIAG_W-1:0]  req_diagonal;
   logic               req_push;
   logic               req_full;
   logic [ID_W-1:0]    rsp_blob_id;
   logic [SLOT_W-1:0]  rsp_slot;
   logic               rsp_is_new;
   logic               rsp_dropped;
   logic               rsp_empty;
   logic               rsp_pop;

   int fail_count;
   int outstanding;
   int idle_cycles;
   bit squeeze_req = 0;

   // recent centers, used to aim new blobs near existing tracks
   int hist_x [$];
   int hist_y [$];

   nearest_blob_track_table DUT (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_wdata    (csr_wdata),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_diagonal (req_diagonal),
      .req_push     (req_push),
      .req_full     (req_full),
      .rsp_blob_id  (rsp_blob_id),
      .rsp_slot     (rsp_slot),
      .rsp_is_new   (rsp_is_new),
      .rsp_dropped  (rsp_dropped),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop)
   );

   track_result_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_wdata    (csr_wdata),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_diagonal (req_diagonal),
      .req_push     (req_push),
      .req_full     (req_full),
      .rsp_blob_id  (rsp_blob_id),
      .rsp_slot     (rsp_slot),
      .rsp_is_new   (rsp_is_new),
      .rsp_dropped  (rsp_dropped),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .fail_count   (fail_count),
      .outstanding  (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // gap length: mostly none or short, now and then long
   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50)
         return 0;
      else if (r < 88)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 80);
   endfunction

   function automatic int clip_coord(input int v);
      if (v < 0)
         return 0;
      else if (v > 4095)
         return 4095;
      else
         return v;
   endfunction

   // watchdog: any stretch with nothing accepted on any channel
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // receiver: random pop pattern, bursts, and one long hold-off on request
   initial begin
      int  on_len;
      int  gap;
      bit  squeezed;
      squeezed = 0;
      rsp_pop <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (squeeze_req && !squeezed) begin
            // hold off long enough that the input queue backs up
            rsp_pop <= 1'b0;
            repeat (SQUEEZE_CYCLES) @(posedge clock);
            squeezed = 1;
         end
         on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
                                              : $urandom_range(1, 8);
         rsp_pop <= 1'b1;
         repeat (on_len) @(posedge clock);
         gap = pick_gap(0);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // offer one blob, hold until taken, then maybe idle
   task automatic send_blob(input int x, input int y, input int diag, input bit calm);
      int gap;
      req_center_x <= COORD_W'(x);
      req_center_y <= COORD_W'(y);
      req_diagonal <= DIAG_W'(diag);
      req_push     <= 1'b1;
      do @(posedge clock); while (req_full);
      hist_x.insert(hist_x.size(), x);
      hist_y.insert(hist_y.size(), y);
      if (hist_x.size() > 48) begin
         void'(hist_x.pop_front());
         void'(hist_y.pop_front());
      end
      gap = pick_gap(calm);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // wait until every expected result has been popped, then let it settle
   task automatic drain();
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_ratio(input int value);
      drain();
      csr_wdata <= RATIO_W'(value);
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // one random blob: mostly near a recent center, the rest noise, edges or midpoints
   task automatic random_blob(input bit calm);
      int mode;
      int pick;
      int other;
      int rad;
      int x;
      int y;
      int diag;
      mode = $urandom_range(0, 99);
      pick = $urandom_range(0, hist_x.size() - 1);
      case ($urandom_range(0, 4))
         0: rad = 0;
         1: rad = 1;
         2: rad = 4;
         3: rad = 30;
         default: rad = 300;
      endcase
      if ($urandom_range(0, 9) == 0)
         diag = $urandom_range(0, 1) ? 0 : 8191;
      else if ($urandom_range(0, 9) < 7)
         diag = $urandom_range(8, 400);
      else
         diag = $urandom_range(0, 8191);
      if (mode < 65) begin
         x = clip_coord(hist_x[pick] + $urandom_range(0, 2 * rad) - rad);
         y = clip_coord(hist_y[pick] + $urandom_range(0, 2 * rad) - rad);
      end else if (mode < 80) begin
         x    = $urandom_range(0, 4095);
         y    = $urandom_range(0, 4095);
         diag = $urandom_range(0, 8191);
      end else if (mode < 90) begin
         x = $urandom_range(0, 2) == 0 ? 0 : ($urandom_range(0, 1) ? 4095 : $urandom_range(0, 4095));
         y = $urandom_range(0, 2) == 0 ? 0 : ($urandom_range(0, 1) ? 4095 : $urandom_range(0, 4095));
         case ($urandom_range(0, 2))
            0: diag = 0;
            1: diag = 1;
            default: diag = 8191;
         endcase
      end else begin
         // midpoint of two recent centers: aims at ties between tracks
         other = $urandom_range(0, hist_x.size() - 1);
         x = (hist_x[pick] + hist_x[other]) / 2;
         y = (hist_y[pick] + hist_y[other]) / 2;
      end
      send_blob(x, y, diag, calm);
   endtask

   task automatic random_phase(input int count, input bit squeeze);
      for (int n = 0; n < count; n++) begin
         if (squeeze && n == 100)
            squeeze_req = 1;
         // a quiet-free stretch now and then
         random_blob((n % 200) < 30);
      end
      req_push <= 1'b0;
   endtask

   initial begin
      reset        <= 1'b1;
      req_push     <= 1'b0;
      req_center_x <= '0;
      req_center_y <= '0;
      req_diagonal <= '0;
      csr_valid    <= 1'b0;
      csr_wdata    <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed, ratio still at its reset value of 1.5
      send_blob(0, 0, 0, 0);          // empty table: new track
      send_blob(4095, 4095, 8191, 0); // far corner, huge limit: matches slot 0
      send_blob(0, 0, 0, 0);          // zero diagonal: always new
      send_blob(0, 0, 5, 0);          // same spot: matches
      send_blob(200, 0, 0, 0);        // new track
      send_blob(100, 0, 200, 0);      // equidistant to two tracks: lower slot
      send_blob(100, 3, 2, 0);        // distance exactly at the limit: new
      send_blob(100, 5, 2, 0);        // just inside the limit: matches
      send_blob(200, 0, 0, 0);        // zero distance, zero diagonal: new
      send_blob(4095, 0, 8191, 0);
      send_blob(0, 4095, 1, 0);
      send_blob(2730, 1365, 4096, 0); // alternating bit patterns
      send_blob(1365, 2730, 4095, 0);
      req_push <= 1'b0;

      set_ratio(255);
      random_phase(400, 1);
      set_ratio(1);
      random_phase(300, 0);
      set_ratio(16);
      random_phase(400, 0);
      set_ratio($urandom_range(1, 255));
      random_phase(450, 0);

      drain();
      if (fail_count == 0 && outstanding == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
